[sv/rcq_pkg.sv]
// Shared types and constants for the rank count query block.
// No dependencies; imported by rcq_ctrl and rank_count_query_top.
package rcq_pkg;

    localparam int CMD_W   = 2;
    localparam int IDX_W   = 10;
    localparam int VAL_W   = 32;
    localparam int CNT_W   = 11;
    localparam int CFG_W   = 11;
    localparam logic [CFG_W-1:0] ENTRIES_RESET = 11'd1024;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD_A = 2'd0,
        CMD_LOAD_B = 2'd1,
        CMD_QUERY  = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    typedef struct packed {
        logic             valid;
        logic [CNT_W-1:0] count;
        logic             index_error;
        logic             is_last;
    } t_result;

endpackage

[sv/rcq_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module rcq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[sv/rcq_ctrl.sv]
// Command decode, entries register and B-table scan sequencer.
// Depends on rcq_pkg; drives the two table RAMs instantiated by the top level.
module rcq_ctrl #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [rcq_pkg::CMD_W-1:0]  i_command,
    input  logic [rcq_pkg::IDX_W-1:0]  i_index,
    input  logic [rcq_pkg::VAL_W-1:0]  i_value,
    input  logic                       i_last_query,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [rcq_pkg::CFG_W-1:0]  i_cfg_data,
    output logic                       o_we_a,
    output logic                       o_we_b,
    output logic [AW-1:0]              o_waddr,
    output logic [rcq_pkg::VAL_W-1:0]  o_wdata,
    output logic                       o_re_a,
    output logic [AW-1:0]              o_raddr_a,
    input  logic [rcq_pkg::VAL_W-1:0]  i_rdata_a,
    output logic                       o_re_b,
    output logic [AW-1:0]              o_raddr_b,
    input  logic [rcq_pkg::VAL_W-1:0]  i_rdata_b,
    output rcq_pkg::t_result           o_result
);

    import rcq_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } t_state;

    t_state           r_state;
    logic [CFG_W-1:0] r_entries;
    logic [AW-1:0]    r_scan;
    logic [CNT_W-1:0] r_count;
    logic             r_last;
    t_result          r_result;

    logic [CFG_W-1:0] n_used;
    logic             accept;
    logic             in_range;
    logic             idx_ok;
    logic             is_le;
    logic             scan_end;
    logic [CNT_W-1:0] n_count;
    logic [AW-1:0]    idx_addr;

    assign accept   = start && !busy;
    assign busy     = (r_state != ST_IDLE);
    // hold off register writes while a query scans or a command is offered
    assign o_cfg_ready = !busy && !start;

    // entries in use saturate at the table depth
    assign n_used   = (32'(r_entries) > DEPTH) ? CFG_W'(DEPTH) : r_entries;
    assign in_range = (32'(i_index) < DEPTH);
    assign idx_ok   = (32'(i_index) < 32'(n_used));
    assign idx_addr = AW'(32'(i_index));

    assign is_le    = ($signed(i_rdata_b) <= $signed(i_rdata_a));
    assign n_count  = r_count + CNT_W'(is_le);
    assign scan_end = ((32'(r_scan) + 32'd1) == 32'(n_used));

    always_comb begin
        o_we_a    = 1'b0;
        o_we_b    = 1'b0;
        o_re_a    = 1'b0;
        o_re_b    = 1'b0;
        o_waddr   = idx_addr;
        o_wdata   = i_value;
        o_raddr_a = idx_addr;
        o_raddr_b = r_scan + AW'(1);
        if (accept) begin
            case (i_command)
                CMD_LOAD_A: o_we_a = in_range;
                CMD_LOAD_B: o_we_b = in_range;
                CMD_QUERY: begin
                    o_re_a    = idx_ok;
                    o_re_b    = idx_ok;
                    o_raddr_b = '0;
                end
                default: ;
            endcase
        end else if (r_state == ST_SCAN) begin
            o_re_b = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ST_IDLE;
            r_entries       <= ENTRIES_RESET;
            r_result.valid  <= 1'b0;
        end else begin
            r_result.valid <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                r_entries <= i_cfg_data;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (accept && i_command == CMD_QUERY) begin
                        r_last  <= i_last_query;
                        r_scan  <= '0;
                        r_count <= '0;
                        if (idx_ok) begin
                            r_state <= ST_SCAN;
                        end else begin
                            r_result.valid       <= 1'b1;
                            r_result.count       <= '0;
                            r_result.index_error <= 1'b1;
                            r_result.is_last     <= i_last_query;
                        end
                    end
                end
                ST_SCAN: begin
                    // B[r_scan] is on the read port; A[index] held since the query
                    r_count <= n_count;
                    r_scan  <= r_scan + AW'(1);
                    if (scan_end) begin
                        r_state              <= ST_IDLE;
                        r_result.valid       <= 1'b1;
                        r_result.count       <= n_count;
                        r_result.index_error <= 1'b0;
                        r_result.is_last     <= r_last;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_result = r_result;

endmodule

[sv/rank_count_query_top.sv]
// Rank count query: counts entries of table B not above A[index].
// Depends on rcq_pkg, rcq_ram and rcq_ctrl.
//
// Usage:
//   Command channel: an item transfers at a rising edge with start high and
//   busy low. Command 0 writes i_value into table A at i_index, command 1 into
//   table B; loads beyond DEPTH are dropped and loads give no result. Command 2
//   queries A[i_index]; command 3 is ignored.
//   Configuration: i_cfg_data sets entries in use (saturated at DEPTH) on an
//   edge with i_cfg_valid and o_cfg_ready high; o_cfg_ready is low while busy
//   or start is high, so the register never changes under a query.
//   Result: o_valid pulses for one cycle with o_count, o_index_error and
//   o_is_last; the receiver cannot stall and must take it in that cycle.
//   Timing: a query with an index below entries in use is paced by the B table
//   scan of one RAM read per cycle over N entries (N = effective entries); its
//   result shows the cycle after the last compare, when busy has already
//   dropped. A query with a bad index answers the next cycle and keeps busy low.
//   Reset: synchronous, active low; clears control state and sets entries in
//   use to 1024. Table contents are undefined until written.
module rank_count_query_top #(
    parameter int DEPTH = 1024
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [rcq_pkg::CMD_W-1:0]  i_command,
    input  logic [rcq_pkg::IDX_W-1:0]  i_index,
    input  logic signed [rcq_pkg::VAL_W-1:0] i_value,
    input  logic                       i_last_query,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [rcq_pkg::CFG_W-1:0]  i_cfg_data,
    output logic                       o_valid,
    output logic [rcq_pkg::CNT_W-1:0]  o_count,
    output logic                       o_index_error,
    output logic                       o_is_last
);

    import rcq_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic             we_a;
    logic             we_b;
    logic [AW-1:0]    waddr;
    logic [VAL_W-1:0] wdata;
    logic             re_a;
    logic             re_b;
    logic [AW-1:0]    raddr_a;
    logic [AW-1:0]    raddr_b;
    logic [VAL_W-1:0] rdata_a;
    logic [VAL_W-1:0] rdata_b;
    t_result          result;

    rcq_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_command    (i_command),
        .i_index      (i_index),
        .i_value      (i_value),
        .i_last_query (i_last_query),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .o_we_a       (we_a),
        .o_we_b       (we_b),
        .o_waddr      (waddr),
        .o_wdata      (wdata),
        .o_re_a       (re_a),
        .o_raddr_a    (raddr_a),
        .i_rdata_a    (rdata_a),
        .o_re_b       (re_b),
        .o_raddr_b    (raddr_b),
        .i_rdata_b    (rdata_b),
        .o_result     (result)
    );

    rcq_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    ) u_table_a (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re_a),
        .i_raddr (raddr_a),
        .o_rdata (rdata_a)
    );

    rcq_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    ) u_table_b (
        .i_clk   (i_clk),
        .i_we    (we_b),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re_b),
        .i_raddr (raddr_b),
        .o_rdata (rdata_b)
    );

    assign o_valid       = result.valid;
    assign o_count       = result.count;
    assign o_index_error = result.index_error;
    assign o_is_last     = result.is_last;

endmodule
